// File: hdl/isfp_pkg.sv
// ----------------------------------------------------------------------------
// isfp_pkg: shared types and constants for the IMU serial frame parser
// Byte codes, frame mode codes and the result record passed between stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package isfp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned POS_W   = 4;
  localparam int unsigned MODE_W  = 2;
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned AXIS_W  = 16;
  localparam int unsigned KEPT_BYTES = 6;

  localparam logic [BYTE_W-1:0] HDR_BYTE   = 8'h55;
  localparam logic [BYTE_W-1:0] TYPE_ACC   = 8'h51;
  localparam logic [BYTE_W-1:0] TYPE_GYRO  = 8'h52;
  localparam logic [BYTE_W-1:0] TYPE_ANGLE = 8'h53;

  // Byte positions within a frame
  localparam logic [POS_W-1:0] POS_HDR   = 4'd0;
  localparam logic [POS_W-1:0] POS_TYPE  = 4'd1;
  localparam logic [POS_W-1:0] POS_DATA  = 4'd2;
  localparam logic [POS_W-1:0] POS_CHECK = 4'd10;

  // Frame modes: hunting, or collecting a frame of a given kind
  localparam logic [MODE_W-1:0] MODE_HUNT  = 2'd0;

  // Frame kinds reported on the result
  localparam logic [KIND_W-1:0] KIND_ACC   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GYRO  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ANGLE = 2'd2;

  typedef struct packed {
    logic                     valid;
    logic [KIND_W-1:0]        kind;
    logic signed [AXIS_W-1:0] x;
    logic signed [AXIS_W-1:0] y;
    logic signed [AXIS_W-1:0] z;
  } result_t;

endpackage

`default_nettype wire

// File: hdl/imu_serial_frame_parser_unit.sv
// ----------------------------------------------------------------------------
// imu_serial_frame_parser_unit: 11-byte IMU serial frame parser
// Finds header/type/payload/checksum frames in a byte stream and reports
// each good frame's kind and three signed 16-bit axis counts.
// ----------------------------------------------------------------------------
// The block takes one received byte per item and accepts a new byte in every
// cycle in which the input register is empty or advancing. A byte passes
// through an input register, the step logic that updates the frame state and
// a result register; a frame's result is loaded there when its checksum byte
// steps, which waits while an earlier result is still held. Sustained rate is
// one byte per cycle; it drops only while a finished result waits in the
// result register and the input register is also full. A frame is 0x55, a
// type byte (0x51 acceleration, 0x52 angular rate, 0x53 angle), eight
// payload bytes and a checksum equal to the low byte of the sum of the ten
// bytes before it. Bytes between the header and a type byte are ignored.
// Frames with a bad checksum produce no item. frame_kind is 0, 1 or 2; the
// axis counts scale as 16 g, 2000 deg/s or 180 deg over 32768.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module imu_serial_frame_parser_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [isfp_pkg::BYTE_W-1:0]  rx_byte,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [isfp_pkg::KIND_W-1:0]        frame_kind,
  output logic signed [isfp_pkg::AXIS_W-1:0] axis_x,
  output logic signed [isfp_pkg::AXIS_W-1:0] axis_y,
  output logic signed [isfp_pkg::AXIS_W-1:0] axis_z
);
  import isfp_pkg::*;

  logic              byte_valid;
  logic [BYTE_W-1:0] byte_q;
  logic              step_en;
  result_t           res;

  // Advance the held byte when the result register is free or draining
  assign step_en  = byte_valid && (!out_valid || out_ready);
  // Take a new byte whenever the input register is empty or advancing
  assign in_ready = !byte_valid || step_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      byte_valid <= 1'b1;
    end else if (step_en) begin
      byte_valid <= 1'b0;
    end
  end

  // Hold the received byte; no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_q <= rx_byte;
    end
  end

  isfp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step_en (step_en),
    .b       (byte_q),
    .res     (res)
  );

  isfp_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load       (step_en),
    .res        (res),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .frame_kind (frame_kind),
    .axis_x     (axis_x),
    .axis_y     (axis_y),
    .axis_z     (axis_z)
  );

endmodule

`default_nettype wire

// File: hdl/isfp_parser.sv
// ----------------------------------------------------------------------------
// isfp_parser: frame state and per-byte step logic
// Tracks header, type, payload and checksum; emits one result per good frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module isfp_parser (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        step_en,
  input  wire logic [isfp_pkg::BYTE_W-1:0] b,
  output isfp_pkg::result_t                res
);
  import isfp_pkg::*;

  logic [MODE_W-1:0] frame_mode, frame_mode_next;
  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic [BYTE_W-1:0] running_sum, running_sum_next;
  logic [BYTE_W-1:0] payload_store [KEPT_BYTES];

  logic              store_en;
  logic [2:0]        store_idx;
  logic [POS_W-1:0]  data_idx;
  logic              is_type;

  assign is_type  = (b == TYPE_ACC) || (b == TYPE_GYRO) || (b == TYPE_ANGLE);
  assign data_idx = byte_position - POS_DATA;
  assign store_idx = data_idx[2:0];

  always_comb begin
    frame_mode_next    = frame_mode;
    byte_position_next = byte_position;
    running_sum_next   = running_sum;
    store_en           = 1'b0;
    res.valid          = 1'b0;
    res.kind           = frame_mode - MODE_W'(1);
    res.x = {payload_store[1], payload_store[0]};
    res.y = {payload_store[3], payload_store[2]};
    res.z = {payload_store[5], payload_store[4]};
    if (frame_mode == MODE_HUNT) begin
      if (byte_position == POS_HDR) begin
        if (b == HDR_BYTE) begin
          running_sum_next   = HDR_BYTE;
          byte_position_next = POS_TYPE;
        end
      end else if (byte_position == POS_TYPE) begin
        // Ignore anything but a type byte; the header stays pending
        if (is_type) begin
          running_sum_next   = running_sum + b;
          frame_mode_next    = b[MODE_W-1:0];
          byte_position_next = POS_DATA;
        end
      end
    end else if (byte_position >= POS_DATA && byte_position < POS_CHECK) begin
      store_en           = (data_idx < POS_W'(KEPT_BYTES));
      running_sum_next   = running_sum + b;
      byte_position_next = byte_position + POS_W'(1);
    end else begin
      // Checksum byte: end the frame either way
      res.valid          = (b == running_sum);
      frame_mode_next    = MODE_HUNT;
      byte_position_next = POS_HDR;
      running_sum_next   = '0;
    end
    res.valid = res.valid & step_en;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_mode    <= MODE_HUNT;
      byte_position <= POS_HDR;
      running_sum   <= '0;
    end else if (step_en) begin
      frame_mode    <= frame_mode_next;
      byte_position <= byte_position_next;
      running_sum   <= running_sum_next;
    end
  end

  always_ff @(posedge clk) begin
    if (step_en && store_en) begin
      payload_store[store_idx] <= b;
    end
  end

endmodule

`default_nettype wire

// File: hdl/isfp_out_reg.sv
// ----------------------------------------------------------------------------
// isfp_out_reg: result register
// Holds one decoded frame until the downstream side takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module isfp_out_reg (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               load,
  input  wire isfp_pkg::result_t  res,
  input  wire logic               out_ready,
  output logic                    out_valid,
  output logic [isfp_pkg::KIND_W-1:0]        frame_kind,
  output logic signed [isfp_pkg::AXIS_W-1:0] axis_x,
  output logic signed [isfp_pkg::AXIS_W-1:0] axis_y,
  output logic signed [isfp_pkg::AXIS_W-1:0] axis_z
);
  import isfp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load && res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && res.valid) begin
      frame_kind <= res.kind;
      axis_x     <= res.x;
      axis_y     <= res.y;
      axis_z     <= res.z;
    end
  end

endmodule

`default_nettype wire
